// ===== src/lcl_pkg.sv =====
// Shared types, codes and constants of the lattice cluster labeler.
package lcl_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 2'd3;

  localparam logic [6:0] RESET_ROWS   = 7'd10;
  localparam logic [6:0] RESET_COLS   = 7'd10;
  localparam logic [6:0] RESET_LEVELS = 7'd10;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  // Neighbour probe codes; the site itself is probed first.
  localparam logic [2:0] NB_ROW_LO = 3'd0;
  localparam logic [2:0] NB_ROW_HI = 3'd1;
  localparam logic [2:0] NB_COL_LO = 3'd2;
  localparam logic [2:0] NB_COL_HI = 3'd3;
  localparam logic [2:0] NB_LVL_LO = 3'd4;
  localparam logic [2:0] NB_LVL_HI = 3'd5;
  localparam logic [2:0] NB_SELF   = 3'd6;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_CLEARED   = 3'd1,
    ST_BAD_SITE  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  typedef struct packed {
    logic       opcode;
    logic [5:0] site_row;
    logic [5:0] site_col;
    logic [5:0] site_level;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        spanned;
    logic [9:0]  cluster_label;
    logic [13:0] fill_count;
    logic [9:0]  live_clusters;
    logic [9:0]  labels_issued;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_SIZE1, S_SIZE2, S_CHECK, S_A1, S_A2,
    S_RD, S_EVAL, S_FRD, S_FOR, S_MERGE, S_FIN
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       zero_counts;
    logic       cnt_zero;
    logic       sweep_clr;
    logic       sweep_merge;
    logic       capture_self;
    logic       capture_seen;
    logic       flag_or;
    logic       merge_start;
    logic       finish;
    logic       report;
    status_t    report_code;
    logic [2:0] nb;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic too_big;
    logic bad_coord;
    logic site_nonzero;
    logic seen_skip;
    logic lab_zero;
    logic labels_full;
    logic cnt_last_site;
    logic cnt_at_end;
  } sts_t;

endpackage

// ===== src/lcl_ram.sv =====
// Generic one-write, one-read RAM with registered read data.
module lcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lcl_ctrl.sv =====
// Sequencer of the lattice cluster labeler.
module lcl_ctrl import lcl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t     state, state_next;
  logic [2:0] nb, nb_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      nb    <= NB_SELF;
    end else begin
      state <= state_next;
      nb    <= nb_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    nb_next         = nb;
    cmd             = '0;
    cmd.report_code = ST_PLACED;
    cmd.nb          = nb;
    unique case (state)
      S_INIT: begin
        cmd.sweep_clr = 1'b1;
        if (sts.cnt_last_site) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch    = 1'b1;
          cmd.cnt_zero = 1'b1;
          if (sts.op_clear) begin
            cmd.zero_counts = 1'b1;
            state_next      = S_CLR;
          end else begin
            state_next = S_SIZE1;
          end
        end
      end
      S_CLR: begin
        cmd.sweep_clr = 1'b1;
        if (sts.cnt_last_site) begin
          cmd.report      = 1'b1;
          cmd.report_code = ST_CLEARED;
          state_next      = S_IDLE;
        end
      end
      S_SIZE1: state_next = S_SIZE2;
      S_SIZE2: state_next = S_CHECK;
      S_CHECK: begin
        if (sts.too_big) begin
          cmd.report      = 1'b1;
          cmd.report_code = ST_TOO_LARGE;
          state_next      = S_IDLE;
        end else if (sts.bad_coord) begin
          cmd.report      = 1'b1;
          cmd.report_code = ST_BAD_SITE;
          state_next      = S_IDLE;
        end else begin
          nb_next    = NB_SELF;
          state_next = S_A1;
        end
      end
      S_A1: state_next = S_A2;
      S_A2: state_next = S_RD;
      S_RD: state_next = S_EVAL;
      S_EVAL: begin
        if (nb == NB_SELF) begin
          cmd.capture_self = 1'b1;
          if (sts.site_nonzero) begin
            cmd.report      = 1'b1;
            cmd.report_code = ST_BAD_SITE;
            state_next      = S_IDLE;
          end else begin
            nb_next    = NB_ROW_LO;
            state_next = S_A1;
          end
        end else begin
          cmd.capture_seen = 1'b1;
          if (!sts.seen_skip) begin
            state_next = S_FRD;
          end else if (nb == NB_LVL_HI) begin
            state_next = S_FIN;
          end else begin
            nb_next    = nb + 3'd1;
            state_next = S_A1;
          end
        end
      end
      S_FRD: state_next = S_FOR;
      S_FOR: begin
        cmd.flag_or = 1'b1;
        if (!sts.lab_zero) begin
          cmd.merge_start = 1'b1;
          cmd.cnt_zero    = 1'b1;
          state_next      = S_MERGE;
        end else if (nb == NB_LVL_HI) begin
          state_next = S_FIN;
        end else begin
          nb_next    = nb + 3'd1;
          state_next = S_A1;
        end
      end
      S_MERGE: begin
        cmd.sweep_merge = 1'b1;
        if (sts.cnt_at_end) begin
          if (nb == NB_LVL_HI) begin
            state_next = S_FIN;
          end else begin
            nb_next    = nb + 3'd1;
            state_next = S_A1;
          end
        end
      end
      S_FIN: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
        if (sts.lab_zero && sts.labels_full) begin
          cmd.report_code = ST_EXHAUSTED;
        end else begin
          cmd.finish      = 1'b1;
          cmd.report_code = ST_PLACED;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/lcl_dp.sv =====
// Datapath of the lattice cluster labeler: stores, address unit, counts, result.
module lcl_dp import lcl_pkg::*; #(
  parameter int MAX_SITES  = 8192,
  parameter int MAX_LABELS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  done,
  output result_t               result
);

  localparam int AW = $clog2(MAX_SITES);
  localparam int CW = $clog2(MAX_SITES + 1);
  localparam int LW = $clog2(MAX_LABELS);

  // configuration
  logic [6:0] rows, cols, levels;
  logic       wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows   <= RESET_ROWS;
      cols   <= RESET_COLS;
      levels <= RESET_LEVELS;
      wrap   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:   rows   <= cfg_data;
        REG_COLS:   cols   <= cfg_data;
        REG_LEVELS: levels <= cfg_data;
        REG_WRAP:   wrap   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // item under work
  logic [5:0] r, c, l;
  logic [6:0] r7, c7, l7;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r <= item.site_row;
      c <= item.site_col;
      l <= item.site_level;
    end
  end

  assign r7 = {1'b0, r};
  assign c7 = {1'b0, c};
  assign l7 = {1'b0, l};

  // lattice size, two registered products
  logic [13:0] p1;
  logic [20:0] p2;

  always_ff @(posedge clk) begin
    p1 <= {7'b0, rows} * {7'b0, cols};
    p2 <= {7'b0, p1} * {14'b0, levels};
  end

  // neighbour coordinates
  logic [6:0] nr, nc, nl;

  always_comb begin
    nr = r7;
    nc = c7;
    nl = l7;
    case (cmd.nb)
      NB_ROW_LO: if (r7 != 7'd0) nr = r7 - 7'd1;
      NB_ROW_HI: if (r7 + 7'd1 < rows) nr = r7 + 7'd1;
      NB_COL_LO: begin
        if (c7 != 7'd0) nc = c7 - 7'd1;
        else            nc = wrap ? cols - 7'd1 : 7'd0;
      end
      NB_COL_HI: begin
        if (c7 + 7'd1 < cols) nc = c7 + 7'd1;
        else                  nc = wrap ? 7'd0 : cols - 7'd1;
      end
      NB_LVL_LO: if (l7 != 7'd0) nl = l7 - 7'd1;
      NB_LVL_HI: if (l7 + 7'd1 < levels) nl = l7 + 7'd1;
      default: ;
    endcase
  end

  // address unit: (row*cols + col)*levels + level over two stages
  logic [13:0] prod1;
  logic [14:0] t_reg;
  logic [6:0]  nl_reg;
  logic [21:0] prod2;
  logic [21:0] a_reg;

  assign prod1 = {7'b0, nr} * {7'b0, cols};
  assign prod2 = {7'b0, t_reg} * {15'b0, levels};

  always_ff @(posedge clk) begin
    t_reg  <= {1'b0, prod1} + {8'b0, nc};
    nl_reg <= nl;
    a_reg  <= prod2 + {15'b0, nl_reg};
  end

  // sweep counter
  logic [CW-1:0] cnt;
  logic [AW-1:0] prev_addr;
  logic          prev_valid;

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_zero) begin
      cnt <= '0;
    end else if (cmd.sweep_clr || cmd.sweep_merge) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
    end else begin
      prev_valid <= cmd.sweep_merge && (cnt != CW'(MAX_SITES));
    end
    prev_addr <= cnt[AW-1:0];
  end

  // labels, flags and counts
  logic [LW-1:0]    lab, seen, gone, lab_f;
  logic [1:0]       lab_flags, flags_f, flag_rdata;
  logic [AW-1:0]    self_addr;
  logic [CW-1:0]    placed;
  logic [LW-1:0]    clusters, next_label;
  logic [LW-1:0]    site_rdata;
  logic             lab_zero;
  logic             at_first, at_last;

  assign lab_zero = (lab == '0);
  assign lab_f    = lab_zero ? next_label + LW'(1) : lab;
  assign at_first = (l7 == 7'd0);
  assign at_last  = (l7 + 7'd1 == levels);
  assign flags_f  = lab_flags | {at_first, at_last};

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lab       <= '0;
      lab_flags <= 2'b00;
    end else if (cmd.flag_or) begin
      lab_flags <= lab_flags | flag_rdata;
      if (lab_zero) lab <= seen;
    end
    if (cmd.capture_seen) seen <= site_rdata;
    if (cmd.capture_self) self_addr <= a_reg[AW-1:0];
    if (cmd.merge_start) gone <= seen;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.zero_counts) begin
      placed     <= '0;
      clusters   <= '0;
      next_label <= '0;
    end else if (cmd.merge_start) begin
      if (clusters != '0) clusters <= clusters - LW'(1);
    end else if (cmd.finish) begin
      placed <= placed + CW'(1);
      if (lab_zero) begin
        next_label <= next_label + LW'(1);
        clusters   <= clusters + LW'(1);
      end
    end
  end

  // site store
  logic          site_we;
  logic [AW-1:0] site_waddr, site_raddr;
  logic [LW-1:0] site_wdata;

  always_comb begin
    site_we    = 1'b0;
    site_waddr = self_addr;
    site_wdata = lab_f;
    if (cmd.sweep_clr) begin
      site_we    = 1'b1;
      site_waddr = cnt[AW-1:0];
      site_wdata = '0;
    end else if (prev_valid && site_rdata == gone) begin
      site_we    = 1'b1;
      site_waddr = prev_addr;
      site_wdata = lab;
    end else if (cmd.finish) begin
      site_we = 1'b1;
    end
  end

  assign site_raddr = cmd.sweep_merge ? cnt[AW-1:0] : a_reg[AW-1:0];

  lcl_ram #(.WIDTH(LW), .DEPTH(MAX_SITES)) u_sites (
    .clk   (clk),
    .we    (site_we),
    .waddr (site_waddr),
    .wdata (site_wdata),
    .raddr (site_raddr),
    .rdata (site_rdata)
  );

  // cluster flags: bit 1 first level, bit 0 last level
  lcl_ram #(.WIDTH(2), .DEPTH(MAX_LABELS)) u_flags (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (lab_f),
    .wdata (flags_f),
    .raddr (seen),
    .rdata (flag_rdata)
  );

  // status back to the sequencer
  assign sts.op_clear      = (item.opcode == OP_CLEAR);
  assign sts.too_big       = (32'(p2) > 32'(MAX_SITES));
  assign sts.bad_coord     = (r7 >= rows) || (c7 >= cols) || (l7 >= levels);
  assign sts.site_nonzero  = (site_rdata != '0);
  assign sts.seen_skip     = (site_rdata == '0) || (!lab_zero && site_rdata == lab);
  assign sts.lab_zero      = lab_zero;
  assign sts.labels_full   = (next_label == LW'(MAX_LABELS - 1));
  assign sts.cnt_last_site = (cnt == CW'(MAX_SITES - 1));
  assign sts.cnt_at_end    = (cnt == CW'(MAX_SITES));

  // result register
  status_t       res_status;
  logic          res_spanned;
  logic [LW-1:0] res_label;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
    if (cmd.report) begin
      res_status <= cmd.report_code;
      if (cmd.finish) begin
        res_spanned <= flags_f[1] & flags_f[0];
        res_label   <= lab_f;
      end else begin
        res_spanned <= 1'b0;
        res_label   <= '0;
      end
    end
  end

  assign result.status        = res_status;
  assign result.spanned       = res_spanned;
  assign result.cluster_label = 10'(res_label);
  assign result.fill_count    = 14'(placed);
  assign result.live_clusters = 10'(clusters);
  assign result.labels_issued = 10'(next_label);

endmodule

// ===== src/lattice_cluster_labeler.sv =====
// Top level of the lattice cluster labeler: sequencer plus datapath.
//
// Incremental cluster labeling on a rows x cols x levels cubic lattice. Raise
// start with an item while busy is low; the item is taken at that edge. Each
// item yields exactly one result, shown on result for the single cycle in
// which done is high; the receiver cannot stall it, so capture it then. A
// clear item sweeps the site store one entry a cycle and then shows its result.
// An add item runs the size check, seven probes through the two-stage address
// multiplier and the registered store read, a flag read for every labeled
// neighbour and a final write, plus a merge sweep of the whole site store for
// every distinct neighbour cluster that is merged.
// After reset busy stays high while the store is cleared; configuration
// writes are taken during that time.
module lattice_cluster_labeler import lcl_pkg::*; #(
  parameter int MAX_SITES  = 8192,
  parameter int MAX_LABELS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  item_t                 item,
  output logic                  busy,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequence each item through size check, probes, merges and final write
  lcl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // hold stores, address arithmetic, counts and the result register
  lcl_dp #(
    .MAX_SITES  (MAX_SITES),
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== verif/lcl_checker.sv =====
// Checker for the lattice cluster labeler: predicts every result and compares it.
module lcl_checker import lcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  item_t                 item,
  input  logic                  done,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSITES  = 8192;
  localparam int NLABELS = 1024;

  logic [9:0] label_store [NSITES];
  bit         at_first [NLABELS];
  bit         at_last [NLABELS];
  int         placed, clusters, issued;
  int         rows, cols, lvls;
  bit         wrap;
  result_t    expected_q [$];

  function automatic int site_index(int r, int c, int l);
    int a;
    a = (r * cols + c) * lvls + l;
    return (a < NSITES) ? a : 0;
  endfunction

  task automatic absorb_cluster(int keep, int gone);
    for (int a = 0; a < NSITES; a++)
      if (int'(label_store[a]) == gone) label_store[a] = 10'(keep);
    if (at_first[gone]) at_first[keep] = 1;
    if (at_last[gone]) at_last[keep] = 1;
    if (clusters > 0) clusters--;
  endtask

  function automatic result_t report(status_t st, bit sp, int lab);
    result_t r;
    r.status        = st;
    r.spanned       = sp;
    r.cluster_label = 10'(lab);
    r.fill_count    = 14'(placed);
    r.live_clusters = 10'(clusters);
    r.labels_issued = 10'(issued);
    return r;
  endfunction

  task automatic label_site(item_t it, output result_t r);
    int rr, cc, ll, self, lab, seen, nr, nc, nl;
    rr = int'(it.site_row);
    cc = int'(it.site_col);
    ll = int'(it.site_level);
    lab = 0;
    if (it.opcode == OP_CLEAR) begin
      foreach (label_store[a]) label_store[a] = '0;
      placed = 0;
      clusters = 0;
      issued = 0;
      r = report(ST_CLEARED, 0, 0);
      return;
    end
    if (rows * cols * lvls > NSITES) begin
      r = report(ST_TOO_LARGE, 0, 0);
      return;
    end
    if (rr >= rows || cc >= cols || ll >= lvls || label_store[site_index(rr, cc, ll)] != 0)
    begin
      r = report(ST_BAD_SITE, 0, 0);
      return;
    end
    self = site_index(rr, cc, ll);
    // Probe the six neighbours; rows and levels clamp, columns clamp or wrap.
    for (int n = 0; n < 6; n++) begin
      nr = rr;
      nc = cc;
      nl = ll;
      case (n)
        0: if (rr > 0) nr = rr - 1;
        1: if (rr + 1 < rows) nr = rr + 1;
        2: nc = (cc > 0) ? cc - 1 : (wrap ? cols - 1 : 0);
        3: nc = (cc + 1 < cols) ? cc + 1 : (wrap ? 0 : cols - 1);
        4: if (ll > 0) nl = ll - 1;
        default: if (ll + 1 < lvls) nl = ll + 1;
      endcase
      seen = int'(label_store[site_index(nr, nc, nl)]);
      if (seen == 0) continue;
      if (lab == 0) begin
        lab = seen;
        label_store[self] = 10'(lab);
      end else if (seen != lab) begin
        absorb_cluster(lab, seen);
      end
    end
    if (lab == 0) begin
      if (issued + 1 >= NLABELS) begin
        r = report(ST_EXHAUSTED, 0, 0);
        return;
      end
      issued++;
      clusters++;
      lab = issued;
      label_store[self] = 10'(lab);
      at_first[lab] = 0;
      at_last[lab] = 0;
    end
    placed++;
    if (ll == 0) at_first[lab] = 1;
    if (ll + 1 == lvls) at_last[lab] = 1;
    r = report(ST_PLACED, at_first[lab] && at_last[lab], lab);
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      foreach (label_store[a]) label_store[a] = '0;
      foreach (at_first[i]) begin
        at_first[i] = 0;
        at_last[i] = 0;
      end
      placed = 0;
      clusters = 0;
      issued = 0;
      rows = int'(RESET_ROWS);
      cols = int'(RESET_COLS);
      lvls = int'(RESET_LEVELS);
      wrap = 0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:   rows = int'(cfg_data);
          REG_COLS:   cols = int'(cfg_data);
          REG_LEVELS: lvls = int'(cfg_data);
          REG_WRAP:   wrap = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        label_site(item, exp_r);
        expected_q.push_back(exp_r);
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %p", result);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (result.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, result.status);
            errors++;
          end
          if (result.spanned !== exp_r.spanned) begin
            $error("spanned: expected %0d, got %0d", exp_r.spanned, result.spanned);
            errors++;
          end
          if (result.cluster_label !== exp_r.cluster_label) begin
            $error("cluster_label: expected %0d, got %0d",
                   exp_r.cluster_label, result.cluster_label);
            errors++;
          end
          if (result.fill_count !== exp_r.fill_count) begin
            $error("fill_count: expected %0d, got %0d", exp_r.fill_count, result.fill_count);
            errors++;
          end
          if (result.live_clusters !== exp_r.live_clusters) begin
            $error("live_clusters: expected %0d, got %0d",
                   exp_r.live_clusters, result.live_clusters);
            errors++;
          end
          if (result.labels_issued !== exp_r.labels_issued) begin
            $error("labels_issued: expected %0d, got %0d",
                   exp_r.labels_issued, result.labels_issued);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the lattice cluster labeler testbench: stimulus, configuration and verdict.
module testbench;
  import lcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case: about a hundred items, each up to about five store sweeps.
  localparam longint CYCLE_LIMIT = 30_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  item_t                 item = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;
  longint                cycles = 0;
  bit                    gaps = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lattice_cluster_labeler u_top (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lcl_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Hang guard: a stuck block never returns its result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic item_t site(logic op, int r, int c, int l);
    item_t it;
    it.opcode     = op;
    it.site_row   = 6'(r);
    it.site_col   = 6'(c);
    it.site_level = 6'(l);
    return it;
  endfunction

  // Offer one item and hold it until the edge that takes it. Called at a
  // rising edge; an optional idle burst drops start first.
  task automatic send(item_t it);
    if (gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic add(int r, int c, int l);
    send(site(OP_ADD, r, c, l));
  endtask

  task automatic clear_lattice();
    send(site(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63)));
  endtask

  // Drop start and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers, one per cycle; call only while idle.
  task automatic set_lattice(int r, int c, int l, bit w);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_ROWS; cfg_data <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_index <= REG_COLS; cfg_data <= CFG_DATA_W'(c);
    @(posedge clk);
    cfg_index <= REG_LEVELS; cfg_data <= CFG_DATA_W'(l);
    @(posedge clk);
    cfg_index <= REG_WRAP; cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int r_dim, c_dim, l_dim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset dimensions: corners, bad coordinates, refill, a two-cluster merge.
    clear_lattice();
    add(0, 0, 0);
    add(0, 0, 0);
    add(9, 9, 9);
    add(10, 0, 0);
    add(0, 10, 0);
    add(0, 0, 10);
    add(63, 63, 63);
    add(2, 0, 0);
    add(1, 0, 0);
    drain();

    // Wrapped ring of four columns, two levels: merge across the seam, spanning.
    set_lattice(1, 4, 2, 1'b1);
    clear_lattice();
    add(0, 0, 0);
    add(0, 3, 1);
    add(0, 3, 0);
    add(0, 1, 1);
    drain();

    // Single level spans at once; a zero dimension rejects every site.
    set_lattice(3, 3, 1, 1'b0);
    add(2, 2, 0);
    add(0, 2, 0);
    drain();
    set_lattice(0, 5, 5, 1'b0);
    add(0, 0, 0);
    drain();

    // Oversized lattices change nothing.
    set_lattice(64, 64, 64, 1'b1);
    add(0, 0, 0);
    drain();
    set_lattice(127, 127, 127, 1'b0);
    add(63, 63, 63);
    drain();

    // Full-size two-level lattice: a row of isolated sites back to back, a
    // merge of two of them, and the far corner.
    set_lattice(64, 64, 2, 1'b0);
    clear_lattice();
    gaps = 1'b0;
    for (int i = 0; i < 24; i++) add((i / 32) * 2, (i % 32) * 2, 0);
    add(0, 1, 0);
    add(63, 63, 1);
    gaps = 1'b1;
    drain();

    // Random phases on small lattices; each keeps the old contents at even odds so
    // that stored labels are read under the new dimensions.
    for (int ph = 0; ph < 8; ph++) begin
      r_dim = $urandom_range(1, 6);
      c_dim = $urandom_range(1, 6);
      l_dim = $urandom_range(1, 6);
      if (ph == 7) begin
        r_dim = 64;
        c_dim = 2;
        l_dim = 2;
      end
      drain();
      set_lattice(r_dim, c_dim, l_dim, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 0) clear_lattice();
      gaps = (ph < 6);
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 19))
          0:       clear_lattice();
          1, 2:    add($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
          default: add($urandom_range(0, r_dim - 1), $urandom_range(0, c_dim - 1),
                       $urandom_range(0, l_dim - 1));
        endcase
      end
      // Hold off once mid-run until everything is back.
      if (ph == 3) drain();
    end
    drain();
    repeat (64) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
